[hdl/pfb_pkg.sv]
// Shared types, codes and constants for the page framebuffer.
package pfb_pkg;

   localparam int PAGE_HEIGHT = 8;
   localparam int HEADER_LEN  = 4;
   // Widest store: 256 columns by 8 pages.
   localparam int ADDR_MAX_W  = 11;

   localparam logic [7:0] CMD_PAGE_ADDR = 8'h22;
   localparam logic [7:0] CMD_COL_LOW   = 8'h00;
   localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

   // Positions of the header bytes within a page.
   localparam logic [1:0] HDR_PAGE_CMD = 2'd0;
   localparam logic [1:0] HDR_PAGE_NUM = 2'd1;
   localparam logic [1:0] HDR_COL_LOW  = 2'd2;
   localparam logic [1:0] HDR_COL_HIGH = 2'd3;

   typedef enum logic [1:0] {
      OP_PIXEL   = 2'd0,
      OP_REFRESH = 2'd1,
      OP_TICK    = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      KIND_PIXEL = 2'd0,
      KIND_CMD   = 2'd1,
      KIND_DATA  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      BK_CLEAR  = 2'd0,
      BK_RUN    = 2'd1,
      BK_MODIFY = 2'd2,
      BK_FETCH  = 2'd3
   } back_state_type;

   typedef struct packed {
      kind_type                kind;
      logic [ADDR_MAX_W-1:0]   addr;
      logic [2:0]              bit_idx;
      logic                    pixel_on;
      logic [7:0]              cmd_byte;
      logic                    last;
   } entry_type;

   function automatic logic [7:0] header_byte(input logic [1:0] idx,
                                              input logic [7:0] page);
      logic [7:0] b;
      b = CMD_PAGE_ADDR;
      unique case (idx)
         HDR_PAGE_CMD: b = CMD_PAGE_ADDR;
         HDR_PAGE_NUM: b = page;
         HDR_COL_LOW:  b = CMD_COL_LOW;
         HDR_COL_HIGH: b = CMD_COL_HIGH;
         default:      b = CMD_PAGE_ADDR;
      endcase
      return b;
   endfunction

endpackage

[hdl/pfb_if.sv]
// Request and response channel interfaces.
interface pfb_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [6:0] pixel_x;
   logic [4:0] pixel_y;
   logic       pixel_on;

   modport source (output valid, opcode, pixel_x, pixel_y, pixel_on, input ready);
   modport sink   (input valid, opcode, pixel_x, pixel_y, pixel_on, output ready);
endinterface

interface pfb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       is_data;
   logic       last_byte;

   modport source (output valid, out_byte, is_data, last_byte, input ready);
   modport sink   (input valid, out_byte, is_data, last_byte, output ready);
endinterface

[hdl/page_framebuffer_with_refresh_core.sv]
// Page framebuffer with display-link refresh readout: top level.
// A command byte passes through the queue and the output register; a data byte also passes the store read register.
// Throughput: the front takes one beat a cycle, while the queue is not full and the
// reset sweep is done, into a two-entry queue; the back handles a command byte in its run
// state, and a data byte or pixel write as one port read, then register or write back.
// Reset: synchronous; clears the frame store one byte a cycle, all COLUMNS*PAGE_COUNT
// bytes (512 by default), with no request beat taken until that sweep ends.
module page_framebuffer_with_refresh_core #(
   parameter int COLUMNS    = 128,
   parameter int PAGE_COUNT = 4
) (
   input logic       clock,
   input logic       reset,
   pfb_req_if.sink   req_ch,
   pfb_rsp_if.source rsp_ch
);

   // Work handed from front to back, in beat order.
   pfb_pkg::entry_type push_entry;
   pfb_pkg::entry_type head;
   logic push, pop, q_empty, q_full;
   // High while the store is being swept after reset.
   logic clear_busy;

   // Front: decodes beats and keeps the refresh position (page, byte in page),
   // so the back only ever sees memory work and ready-made command bytes.
   pfb_front #(
      .COLUMNS    (COLUMNS),
      .PAGE_COUNT (PAGE_COUNT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .q_full     (q_full),
      .clear_busy (clear_busy),
      .q_push     (push),
      .q_entry    (push_entry)
   );

   pfb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (q_empty),
      .full       (q_full)
   );

   // Back: owns the store; in-order execution keeps pixel writes visible to
   // later data reads of the same refresh.
   pfb_back #(
      .COLUMNS    (COLUMNS),
      .PAGE_COUNT (PAGE_COUNT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_empty    (q_empty),
      .q_pop      (pop),
      .clear_busy (clear_busy),
      .rsp        (rsp_ch)
   );

endmodule

[hdl/pfb_front.sv]
// Front end: takes request beats, tracks refresh position, queues work.
module pfb_front #(
   parameter int COLUMNS    = 128,
   parameter int PAGE_COUNT = 4
) (
   input  logic               clock,
   input  logic               reset,
   pfb_req_if.sink            req,
   input  logic               q_full,
   input  logic               clear_busy,
   output logic               q_push,
   output pfb_pkg::entry_type q_entry
);

   localparam int PG_W  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
   localparam int BIP_W = $clog2(COLUMNS + pfb_pkg::HEADER_LEN);
   localparam int AW    = pfb_pkg::ADDR_MAX_W;
   localparam int BIT_W = $clog2(pfb_pkg::PAGE_HEIGHT);

   logic             active_ff, active_in;
   logic [PG_W-1:0]  page_ff, page_in;
   logic [BIP_W-1:0] bip_ff, bip_in;

   logic       accept;
   logic [1:0] pix_page;
   logic       pix_ok;
   logic       end_of_page;
   logic       last_page;

   assign req.ready = !q_full && !clear_busy;
   assign accept    = req.valid && req.ready;

   assign pix_page    = req.pixel_y[4:BIT_W];
   assign pix_ok      = (int'(req.pixel_x) < COLUMNS) && (int'(pix_page) < PAGE_COUNT);
   assign end_of_page = bip_ff == BIP_W'(COLUMNS + pfb_pkg::HEADER_LEN - 1);
   assign last_page   = page_ff == PG_W'(PAGE_COUNT - 1);

   always_comb begin
      active_in = active_ff;
      page_in   = page_ff;
      bip_in    = bip_ff;
      q_push    = 1'b0;
      q_entry   = '0;
      q_entry.bit_idx  = req.pixel_y[BIT_W-1:0];
      q_entry.pixel_on = req.pixel_on;
      if (accept) begin
         unique case (pfb_pkg::op_type'(req.opcode))
            pfb_pkg::OP_PIXEL: begin
               q_push       = pix_ok;
               q_entry.kind = pfb_pkg::KIND_PIXEL;
               q_entry.addr = AW'(int'(pix_page) * COLUMNS + int'(req.pixel_x));
            end
            pfb_pkg::OP_REFRESH: begin
               active_in = 1'b1;
               page_in   = '0;
               bip_in    = '0;
            end
            pfb_pkg::OP_TICK: begin
               if (active_ff) begin
                  q_push       = 1'b1;
                  q_entry.last = end_of_page && last_page;
                  if (int'(bip_ff) < pfb_pkg::HEADER_LEN) begin
                     q_entry.kind     = pfb_pkg::KIND_CMD;
                     q_entry.cmd_byte = pfb_pkg::header_byte(bip_ff[1:0], 8'(page_ff));
                  end else begin
                     q_entry.kind = pfb_pkg::KIND_DATA;
                     q_entry.addr = AW'(int'(page_ff) * COLUMNS + int'(bip_ff)
                                        - pfb_pkg::HEADER_LEN);
                  end
                  if (end_of_page) begin
                     bip_in = '0;
                     if (last_page) begin
                        active_in = 1'b0;
                        page_in   = '0;
                     end else begin
                        page_in = page_ff + 1'b1;
                     end
                  end else begin
                     bip_in = bip_ff + 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         page_ff   <= '0;
         bip_ff    <= '0;
      end else begin
         active_ff <= active_in;
         page_ff   <= page_in;
         bip_ff    <= bip_in;
      end
   end

endmodule

[hdl/pfb_queue.sv]
// Two-entry queue between front and back end.
module pfb_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pfb_pkg::entry_type push_entry,
   input  logic               pop,
   output pfb_pkg::entry_type head,
   output logic               empty,
   output logic               full
);

   pfb_pkg::entry_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign empty = count_ff == 2'd0;
   assign full  = count_ff == 2'd2;
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[hdl/pfb_back.sv]
// Back end: frame store, pixel read-modify-write and byte output register.
module pfb_back #(
   parameter int COLUMNS    = 128,
   parameter int PAGE_COUNT = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  pfb_pkg::entry_type head,
   input  logic               q_empty,
   output logic               q_pop,
   output logic               clear_busy,
   pfb_rsp_if.source          rsp
);

   localparam int DEPTH  = COLUMNS * PAGE_COUNT;
   localparam int ADDR_W = $clog2(DEPTH);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   pfb_pkg::back_state_type state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   pfb_pkg::entry_type cur_ff;

   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_data_ff, out_data_in;
   logic       out_last_ff, out_last_in;

   logic              out_free;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_wa, mem_ra;
   logic [7:0]        mem_wd;
   logic [7:0]        bit_mask;
   logic              load_cmd, load_data;

   assign out_free   = !out_valid_ff || rsp.ready;
   assign clear_busy = state_ff == pfb_pkg::BK_CLEAR;
   assign bit_mask   = 8'b1 << cur_ff.bit_idx;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pfb_pkg::BK_CLEAR: begin
            if (clr_ff == ADDR_W'(DEPTH - 1)) state_in = pfb_pkg::BK_RUN;
         end
         pfb_pkg::BK_RUN: begin
            if (!q_empty) begin
               case (head.kind)
                  pfb_pkg::KIND_PIXEL: state_in = pfb_pkg::BK_MODIFY;
                  pfb_pkg::KIND_DATA:  if (out_free) state_in = pfb_pkg::BK_FETCH;
                  default: ;
               endcase
            end
         end
         pfb_pkg::BK_MODIFY: state_in = pfb_pkg::BK_RUN;
         pfb_pkg::BK_FETCH:  state_in = pfb_pkg::BK_RUN;
         default:            state_in = pfb_pkg::BK_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      q_pop     = 1'b0;
      mem_we    = 1'b0;
      mem_wa    = clr_ff;
      mem_wd    = '0;
      mem_ra    = head.addr[ADDR_W-1:0];
      load_cmd  = 1'b0;
      load_data = 1'b0;
      clr_in    = clr_ff;
      unique case (state_ff)
         pfb_pkg::BK_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + 1'b1;
         end
         pfb_pkg::BK_RUN: begin
            if (!q_empty) begin
               case (head.kind)
                  pfb_pkg::KIND_PIXEL: q_pop = 1'b1;
                  pfb_pkg::KIND_CMD: begin
                     q_pop    = out_free;
                     load_cmd = out_free;
                  end
                  pfb_pkg::KIND_DATA: q_pop = out_free;
                  default: q_pop = 1'b1;
               endcase
            end
         end
         pfb_pkg::BK_MODIFY: begin
            mem_we = 1'b1;
            mem_wa = cur_ff.addr[ADDR_W-1:0];
            mem_wd = cur_ff.pixel_on ? (rd_data_ff | bit_mask) : (rd_data_ff & ~bit_mask);
         end
         pfb_pkg::BK_FETCH: load_data = 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp.ready;
      out_byte_in  = out_byte_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      if (load_cmd) begin
         out_valid_in = 1'b1;
         out_byte_in  = head.cmd_byte;
         out_data_in  = 1'b0;
         out_last_in  = head.last;
      end else if (load_data) begin
         out_valid_in = 1'b1;
         out_byte_in  = rd_data_ff;
         out_data_in  = 1'b1;
         out_last_in  = cur_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (q_pop) cur_ff <= head;
      out_byte_ff <= out_byte_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfb_pkg::BK_CLEAR;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.out_byte  = out_byte_ff;
   assign rsp.is_data   = out_data_ff;
   assign rsp.last_byte = out_last_ff;

endmodule

[tb/page_framebuffer_with_refresh_core_tb.sv]
// Self-checking testbench for the page framebuffer with display-link refresh readout.
`timescale 1ns / 100ps

module page_framebuffer_with_refresh_core_tb;

   localparam int COLUMNS     = 128;
   localparam int PAGE_COUNT  = 4;
   localparam int LINE_LEN    = pfb_pkg::HEADER_LEN + COLUMNS;  // beats per page
   localparam int FRAME_BEATS = PAGE_COUNT * LINE_LEN;          // beats per whole refresh
   localparam int STORE_BYTES = COLUMNS * PAGE_COUNT;

   // Opcode three has no meaning; the block must drop it.
   localparam logic [1:0] OP_SPARE = 2'd3;

   localparam int ITEM_TOTAL   = 1850;
   localparam int DRAIN_CYCLES = 16;
   // Reset sweep plus ~2000 beats at worst-case gaps and stalls, many times over.
   localparam int CYCLE_LIMIT  = 200000;

   typedef struct packed {
      logic [7:0] value;
      logic       is_data;
      logic       last;
   } link_byte_type;

   logic clock;
   logic reset;

   pfb_req_if req_if ();
   pfb_rsp_if rsp_if ();

   page_framebuffer_with_refresh_core #(
      .COLUMNS    (COLUMNS),
      .PAGE_COUNT (PAGE_COUNT)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // ---------------------------------------------------------------------
   // Predictor state: own copy of the frame store and the readout pointer
   // ---------------------------------------------------------------------
   bit [7:0]   frame_image [STORE_BYTES];
   bit         scan_on;
   int         scan_page;
   int         scan_pos;          // 0..3 header, then data columns

   link_byte_type link_bytes_due [$];

   int send_idle_pct;             // chance of a gap before each request beat
   int stall_pct;                 // chance of ready low on the link side
   int items_counted;             // beats other than ticks with no refresh running and opcode three
   int items_ignored;
   int bytes_checked;
   int frames_done;
   int mismatches;
   int cycle_count;

   always #2 clock = ~clock;

   // Run guard: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: cycle limit reached, %0d link bytes still due",
                  $time, link_bytes_due.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Predictor: applies one accepted request beat, queues any link byte
   // ---------------------------------------------------------------------
   task automatic predict_link_byte(input logic [1:0] op, input logic [6:0] x,
                                    input logic [4:0] y, input logic on,
                                    output bit effective);
      int            row_page;
      int            addr;
      link_byte_type beat;
      effective = 1'b1;
      case (op)
         pfb_pkg::OP_PIXEL: begin
            // Rows or columns beyond the store are dropped.
            row_page = int'(y) / pfb_pkg::PAGE_HEIGHT;
            if (int'(x) < COLUMNS && row_page < PAGE_COUNT) begin
               addr = row_page * COLUMNS + int'(x);
               frame_image[addr][int'(y) % pfb_pkg::PAGE_HEIGHT] = on;
            end
         end
         pfb_pkg::OP_REFRESH: begin
            // Restarts from page 0 even mid-frame.
            scan_on   = 1'b1;
            scan_page = 0;
            scan_pos  = 0;
         end
         pfb_pkg::OP_TICK: begin
            if (!scan_on) begin
               effective = 1'b0;
            end else begin
               if (scan_pos < pfb_pkg::HEADER_LEN) begin
                  beat.is_data = 1'b0;
                  case (2'(scan_pos))
                     pfb_pkg::HDR_PAGE_CMD: beat.value = pfb_pkg::CMD_PAGE_ADDR;
                     pfb_pkg::HDR_PAGE_NUM: beat.value = 8'(scan_page);
                     pfb_pkg::HDR_COL_LOW:  beat.value = pfb_pkg::CMD_COL_LOW;
                     default:               beat.value = pfb_pkg::CMD_COL_HIGH;
                  endcase
               end else begin
                  beat.is_data = 1'b1;
                  beat.value   = frame_image[scan_page * COLUMNS + scan_pos
                                             - pfb_pkg::HEADER_LEN];
               end
               beat.last = (scan_page == PAGE_COUNT - 1) && (scan_pos == LINE_LEN - 1);
               link_bytes_due.push_back(beat);
               if (beat.last) begin
                  scan_on   = 1'b0;
                  scan_page = 0;
                  scan_pos  = 0;
                  frames_done++;
               end else if (scan_pos == LINE_LEN - 1) begin
                  scan_pos = 0;
                  scan_page++;
               end else begin
                  scan_pos++;
               end
            end
         end
         default: effective = 1'b0;
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Request side: one beat, with an optional gap ahead of it
   // ---------------------------------------------------------------------
   task automatic send_item(input logic [1:0] op, input logic [6:0] x,
                            input logic [4:0] y, input logic on);
      bit effective;
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.opcode   <= op;
      req_if.pixel_x  <= x;
      req_if.pixel_y  <= y;
      req_if.pixel_on <= on;
      do @(posedge clock); while (!req_if.ready);
      predict_link_byte(op, x, y, on, effective);
      if (effective)
         items_counted++;
      else
         items_ignored++;
   endtask

   // ---------------------------------------------------------------------
   // Link side: check each byte against the oldest prediction, drive stalls
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : link_check
      link_byte_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (link_bytes_due.size() == 0) begin
            $display("%0t: link byte with nothing due: got %h data=%b last=%b",
                     $time, rsp_if.out_byte, rsp_if.is_data, rsp_if.last_byte);
            mismatches++;
         end else begin
            want = link_bytes_due.pop_front();
            if (rsp_if.out_byte !== want.value || rsp_if.is_data !== want.is_data ||
                rsp_if.last_byte !== want.last) begin
               $display({"%0t: link byte mismatch: expected %h data=%b last=%b, ",
                         "got %h data=%b last=%b"},
                        $time, want.value, want.is_data, want.last,
                        rsp_if.out_byte, rsp_if.is_data, rsp_if.last_byte);
               mismatches++;
            end
            bytes_checked++;
         end
      end
      rsp_if.ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Ticks with no refresh running and opcode three: no byte, no effect.
   task automatic test_ignored_items();
      send_item(pfb_pkg::OP_TICK, 7'd0, 5'd0, 1'b0);
      send_item(OP_SPARE, 7'd127, 5'd31, 1'b1);
      send_item(pfb_pkg::OP_TICK, 7'd127, 5'd31, 1'b1);
   endtask

   // Corner pixels, two bits of one byte, and a set followed by a clear.
   task automatic test_pixel_corners();
      send_item(pfb_pkg::OP_PIXEL, 7'd0,   5'd0,  1'b1);
      send_item(pfb_pkg::OP_PIXEL, 7'd127, 5'd0,  1'b1);
      send_item(pfb_pkg::OP_PIXEL, 7'd0,   5'd31, 1'b1);
      send_item(pfb_pkg::OP_PIXEL, 7'd127, 5'd31, 1'b1);
      send_item(pfb_pkg::OP_PIXEL, 7'd1,   5'd7,  1'b1);
      send_item(pfb_pkg::OP_PIXEL, 7'd1,   5'd0,  1'b1);
      send_item(pfb_pkg::OP_PIXEL, 7'd1,   5'd7,  1'b0);
   endtask

   // Header then first data bytes, a write into the byte just ahead,
   // then a restart mid-frame.
   task automatic test_refresh_restart();
      send_item(pfb_pkg::OP_REFRESH, 7'd0, 5'd0, 1'b0);
      repeat (5) send_item(pfb_pkg::OP_TICK, 7'd0, 5'd0, 1'b0);
      send_item(pfb_pkg::OP_PIXEL, 7'd1, 5'd3, 1'b1);
      send_item(pfb_pkg::OP_TICK, 7'd0, 5'd0, 1'b0);
      send_item(pfb_pkg::OP_REFRESH, 7'd127, 5'd31, 1'b1);
      repeat (6) send_item(pfb_pkg::OP_TICK, 7'd0, 5'd0, 1'b0);
   endtask

   // Refresh sequences with random content: mostly ticks, pixel writes that
   // often land on or just ahead of the byte being read, some noise, and
   // restarts that cut frames short. The first frame can be made whole.
   task automatic run_random_phase(input int idle_pct, input int hold_pct,
                                   input int target, input bit whole_first);
      int   start_count;
      int   ticks_left;
      int   pick;
      int   col;
      bit   whole;
      logic [6:0] px;
      logic [4:0] py;
      send_idle_pct = idle_pct;
      stall_pct     = hold_pct;
      start_count   = items_counted;
      whole         = whole_first;
      while (items_counted - start_count < target) begin
         send_item(pfb_pkg::OP_REFRESH, 7'($urandom), 5'($urandom), 1'($urandom));
         if (whole || $urandom_range(0, 5) == 0)
            ticks_left = FRAME_BEATS;
         else
            ticks_left = $urandom_range(1, 200);
         while (ticks_left > 0 && (whole || items_counted - start_count < target)) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
               if (scan_on && scan_pos >= pfb_pkg::HEADER_LEN &&
                   $urandom_range(0, 1) == 1) begin
                  col = scan_pos - pfb_pkg::HEADER_LEN + $urandom_range(0, 2);
                  if (col > COLUMNS - 1)
                     col = COLUMNS - 1;
                  px = 7'(col);
                  py = 5'(scan_page * pfb_pkg::PAGE_HEIGHT +
                          $urandom_range(0, pfb_pkg::PAGE_HEIGHT - 1));
               end else begin
                  px = 7'($urandom_range(0, COLUMNS - 1));
                  py = 5'($urandom_range(0, PAGE_COUNT * pfb_pkg::PAGE_HEIGHT - 1));
               end
               send_item(pfb_pkg::OP_PIXEL, px, py, $urandom_range(0, 99) < 65);
            end else if (pick < 17) begin
               send_item(OP_SPARE, 7'($urandom), 5'($urandom), 1'($urandom));
            end else begin
               send_item(pfb_pkg::OP_TICK, 7'($urandom), 5'($urandom), 1'($urandom));
               ticks_left--;
            end
         end
         // A stray tick once a frame has run out.
         if (ticks_left == 0 && $urandom_range(0, 2) == 0)
            send_item(pfb_pkg::OP_TICK, 7'($urandom), 5'($urandom), 1'($urandom));
         whole = 1'b0;
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.opcode   = pfb_pkg::OP_PIXEL;
      req_if.pixel_x  = '0;
      req_if.pixel_y  = '0;
      req_if.pixel_on = 1'b0;
      rsp_if.ready    = 1'b0;
      scan_on         = 1'b0;
      scan_page       = 0;
      scan_pos        = 0;
      send_idle_pct   = 0;
      stall_pct       = 0;
      items_counted   = 0;
      items_ignored   = 0;
      bytes_checked   = 0;
      frames_done     = 0;
      mismatches      = 0;
      cycle_count     = 0;
      foreach (frame_image[i])
         frame_image[i] = '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // The block sweeps its store after reset; send_item waits on ready.
      test_ignored_items();
      test_pixel_corners();
      test_refresh_restart();

      // Idling phases: none, sender gaps, link stalls, both lightly.
      // A whole-frame phase runs a full frame (~620 beats) past its target.
      run_random_phase(0,  0,  ITEM_TOTAL / 6, 1'b1);
      run_random_phase(55, 0,  ITEM_TOTAL / 6, 1'b0);
      run_random_phase(0,  55, ITEM_TOTAL / 6, 1'b0);
      run_random_phase(10, 10, ITEM_TOTAL / 6, 1'b1);

      req_if.valid <= 1'b0;
      while (link_bytes_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d effective request beats and %0d ignored ones,",
               items_counted, items_ignored);
      $display("with %0d link bytes checked and %0d whole frames read out.",
               bytes_checked, frames_done);
      if (mismatches == 0 && link_bytes_due.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
